### rtl/core/hun_pkg.sv
// Shared types and constants for the hyperplane unit normal core.
// No dependencies; imported by hun_lane, hun_norm and the top level.
package hun_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int FIELD_COUNT = 4;
    localparam int DIM_LIMIT   = (MAX_DIMS < FIELD_COUNT) ? MAX_DIMS : FIELD_COUNT;
    localparam int ROW_DEPTH   = FIELD_COUNT - 1;
    localparam int MAT_SIZE    = ROW_DEPTH * ROW_DEPTH;
    localparam int COMP_W      = 16;
    localparam int ENTRY_W     = COMP_W + 1;
    localparam int COF_W       = 35;
    localparam int DET_W       = 52;
    localparam int MAG_W       = 30;
    localparam int SUM_W       = 62;
    localparam int LEN_W       = 31;
    localparam int QUOT_W      = 15;
    localparam int FRAC_SHIFT  = 14;
    localparam int REM_W       = MAG_W + FRAC_SHIFT + 2;
    localparam int DIM_W       = 3;
    localparam int ROW_IDX_W   = 2;

    typedef logic [MAT_SIZE-1:0][ENTRY_W-1:0]    mat_t;
    typedef logic [FIELD_COUNT-1:0][DET_W-1:0]   det_mag_t;
    typedef logic [FIELD_COUNT-1:0][MAG_W-1:0]   norm_mag_t;

    typedef struct packed {
        logic det_start;
        logic div_start;
    } lane_ctl_t;

    typedef struct packed {
        logic det_done;
        logic div_done;
    } lane_stat_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DET,
        ST_NORM,
        ST_DIV,
        ST_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_DET,
        LN_DIV
    } lane_state_t;

    typedef enum logic [2:0] {
        NM_IDLE,
        NM_MAX,
        NM_SHIFT,
        NM_SQ,
        NM_SQRT
    } norm_state_t;

endpackage

### rtl/core/hun_lane.sv
// One lane: 3x3 minor determinant on a shared multiplier, then a restoring
// divide of one normalized magnitude by the length. Depends on hun_pkg.
module hun_lane
    import hun_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lane_ctl_t                ctl,
    input  mat_t                     mat,
    input  logic [MAG_W-1:0]         mag,
    input  logic [LEN_W-1:0]         len,
    output logic signed [DET_W-1:0]  det,
    output logic [QUOT_W-1:0]        quot,
    output lane_stat_t               stat
);

    lane_state_t             state_reg, state_next;
    logic [3:0]              step_reg, step_next;
    logic signed [COF_W-1:0] cof_reg, cof_next;
    logic signed [DET_W-1:0] det_reg, det_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [REM_W-1:0]        dvs_reg, dvs_next;
    logic [QUOT_W-1:0]       quot_reg, quot_next;
    lane_stat_t              stat_reg, stat_next;
    logic signed [ENTRY_W-1:0] op_a;
    logic signed [COF_W-1:0]   op_b;
    logic signed [DET_W-1:0]   prod;

    // operand select for the cofactor expansion along row 0
    always_comb
    begin
        case (step_reg)
            4'd0:    begin op_a = $signed(mat[4]); op_b = COF_W'($signed(mat[8])); end
            4'd1:    begin op_a = $signed(mat[5]); op_b = COF_W'($signed(mat[7])); end
            4'd2:    begin op_a = $signed(mat[0]); op_b = cof_reg; end
            4'd3:    begin op_a = $signed(mat[3]); op_b = COF_W'($signed(mat[8])); end
            4'd4:    begin op_a = $signed(mat[5]); op_b = COF_W'($signed(mat[6])); end
            4'd5:    begin op_a = $signed(mat[1]); op_b = cof_reg; end
            4'd6:    begin op_a = $signed(mat[3]); op_b = COF_W'($signed(mat[7])); end
            4'd7:    begin op_a = $signed(mat[4]); op_b = COF_W'($signed(mat[6])); end
            4'd8:    begin op_a = $signed(mat[2]); op_b = cof_reg; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod = DET_W'(op_a) * DET_W'(op_b);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cof_next   = cof_reg;
        det_next   = det_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quot_next  = quot_reg;
        stat_next  = '0;
        case (state_reg)
            LN_IDLE:
            begin
                if (ctl.det_start)
                begin
                    state_next = LN_DET;
                    step_next  = '0;
                end
                else if (ctl.div_start)
                begin
                    state_next = LN_DIV;
                    step_next  = 4'(QUOT_W - 1);
                    rem_next   = (REM_W'(mag) << FRAC_SHIFT) + REM_W'(len >> 1);
                    dvs_next   = REM_W'(len) << FRAC_SHIFT;
                    quot_next  = '0;
                end
            end
            LN_DET:
            begin
                case (step_reg)
                    4'd0, 4'd3, 4'd6: cof_next = COF_W'(prod);
                    4'd1, 4'd4, 4'd7: cof_next = cof_reg - COF_W'(prod);
                    4'd2:             det_next = prod;
                    4'd5:             det_next = det_reg - prod;
                    default:          det_next = det_reg + prod;
                endcase
                if (step_reg == 4'd8)
                begin
                    state_next     = LN_IDLE;
                    stat_next.det_done = 1'b1;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            LN_DIV:
            begin
                if (rem_reg >= dvs_reg)
                begin
                    rem_next  = rem_reg - dvs_reg;
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
                end
                dvs_next = dvs_reg >> 1;
                if (step_reg == '0)
                begin
                    state_next     = LN_IDLE;
                    stat_next.div_done = 1'b1;
                end
                else
                begin
                    step_next = step_reg - 4'd1;
                end
            end
            default:
            begin
                state_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LN_IDLE;
            step_reg  <= '0;
            stat_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            stat_reg  <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cof_reg  <= cof_next;
        det_reg  <= det_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign det  = det_reg;
    assign quot = quot_reg;
    assign stat = stat_reg;

endmodule

### rtl/core/hun_norm.sv
// Merge stage: largest magnitude, shift into range, sum of squares and a
// bit-serial integer square root giving the length. Depends on hun_pkg.
module hun_norm
    import hun_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  det_mag_t          mags,
    output norm_mag_t         norm_mags,
    output logic [LEN_W-1:0]  len,
    output logic              zero,
    output logic              done
);

    norm_state_t         state_reg, state_next;
    det_mag_t            mag_reg, mag_next;
    logic [DET_W-1:0]    m_reg, m_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUM_W-1:0]    x_reg, x_next;
    logic [SUM_W-1:0]    res_reg, res_next;
    logic [SUM_W-1:0]    bit_reg, bit_next;
    logic                zero_reg, zero_next;
    logic                done_reg, done_next;
    logic [DET_W-1:0]    max_a, max_b, max_all;
    logic [MAG_W-1:0]    sq_in;
    logic [2*MAG_W-1:0]  sq;
    logic [SUM_W:0]      trial;

    assign max_a   = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
    assign max_b   = (mag_reg[2] > mag_reg[3]) ? mag_reg[2] : mag_reg[3];
    assign max_all = (max_a > max_b) ? max_a : max_b;
    assign sq_in   = mag_reg[cnt_reg][MAG_W-1:0];
    assign sq      = sq_in * sq_in;
    assign trial   = {1'b0, res_reg} + {1'b0, bit_reg};

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        m_next     = m_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        x_next     = x_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        zero_next  = zero_reg;
        done_next  = 1'b0;
        case (state_reg)
            NM_IDLE:
            begin
                if (start)
                begin
                    mag_next   = mags;
                    state_next = NM_MAX;
                end
            end
            NM_MAX:
            begin
                m_next = max_all;
                if (max_all == '0)
                begin
                    zero_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = NM_IDLE;
                end
                else
                begin
                    zero_next  = 1'b0;
                    state_next = NM_SHIFT;
                end
            end
            NM_SHIFT:
            begin
                // move the largest magnitude into [2^29, 2^30)
                if (|m_reg[DET_W-1:MAG_W])
                begin
                    for (int i = 0; i < FIELD_COUNT; i++)
                        mag_next[i] = mag_reg[i] >> 1;
                    m_next = m_reg >> 1;
                end
                else if (!m_reg[MAG_W-1])
                begin
                    for (int i = 0; i < FIELD_COUNT; i++)
                        mag_next[i] = mag_reg[i] << 1;
                    m_next = m_reg << 1;
                end
                else
                begin
                    cnt_next   = '0;
                    sum_next   = '0;
                    state_next = NM_SQ;
                end
            end
            NM_SQ:
            begin
                sum_next = sum_reg + SUM_W'(sq);
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    x_next     = sum_reg + SUM_W'(sq);
                    res_next   = '0;
                    bit_next   = SUM_W'(1) << (SUM_W - 2);
                    state_next = NM_SQRT;
                end
            end
            NM_SQRT:
            begin
                if ({1'b0, x_reg} >= trial)
                begin
                    x_next   = x_reg - trial[SUM_W-1:0];
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    done_next  = 1'b1;
                    state_next = NM_IDLE;
                end
            end
            default:
            begin
                state_next = NM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= NM_IDLE;
            done_reg  <= 1'b0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            zero_reg  <= zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        m_reg   <= m_next;
        cnt_reg <= cnt_next;
        sum_reg <= sum_next;
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    always_comb
    begin
        for (int i = 0; i < FIELD_COUNT; i++)
            norm_mags[i] = mag_reg[i][MAG_W-1:0];
    end

    assign len  = res_reg[LEN_W-1:0];
    assign zero = zero_reg;
    assign done = done_reg;

endmodule

### rtl/core/hyperplane_unit_normal_core.sv
// Top level of the hyperplane unit normal core: row store, sequencer,
// four determinant/divide lanes and the merge stage. Depends on hun_pkg,
// hun_lane and hun_norm.
//
// Usage: write dimension_count (N, 2..4, reset 3) on the cfg channel
// while the core is idle; the write also drops any partly loaded set.
// in_stall is held high while a cfg write is offered, so the write goes
// first and no vector is taken in the same cycle.
// Send N-1 spanning vectors on the input channel (comp_0..comp_3, Q4.12,
// components at or above N ignored), one item per vector. The core takes
// loading items one per cycle while no cfg write is offered. After the
// last vector it computes the unit normal (Q1.14) and presents it on the
// output channel with status 0, or all zeros with status 1 when the
// vectors are collinear. The four lanes first compute their determinants
// (nine steps on one multiplier per lane); the merge stage then shifts the
// magnitudes into range, sums their squares and takes the square root;
// each lane then runs a restoring divide, skipped when all are zero.
// in_stall stays high during that time. The result waits in an output
// register while out_stall is high; the next set of vectors may be
// loaded meanwhile, and only the next result waits. Reset returns to
// the loading state with no rows held.
module hyperplane_unit_normal_core
    import hun_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [DIM_W-1:0]         dimension_count,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [COMP_W-1:0] comp_0,
    input  logic signed [COMP_W-1:0] comp_1,
    input  logic signed [COMP_W-1:0] comp_2,
    input  logic signed [COMP_W-1:0] comp_3,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [COMP_W-1:0] normal_0,
    output logic signed [COMP_W-1:0] normal_1,
    output logic signed [COMP_W-1:0] normal_2,
    output logic signed [COMP_W-1:0] normal_3,
    output logic                     status
);

    top_state_t                 state_reg, state_next;
    logic [DIM_W-1:0]           dim_reg, dim_next;
    logic [ROW_IDX_W-1:0]       rows_loaded_reg, rows_loaded_next;
    logic [FIELD_COUNT*COMP_W-1:0] row_store_reg [ROW_DEPTH];
    logic [FIELD_COUNT-1:0]     neg_reg, neg_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [COMP_W-1:0]   normal_reg [FIELD_COUNT];
    logic signed [COMP_W-1:0]   normal_next [FIELD_COUNT];
    logic                       status_reg, status_next;

    logic [DIM_W-1:0]           n_eff;
    logic [ROW_IDX_W-1:0]       k_eff;
    logic                       in_take, cfg_take, out_take, row_write;
    lane_ctl_t                  lane_ctl;
    lane_stat_t                 lane_stat [FIELD_COUNT];
    mat_t                       lane_mat [FIELD_COUNT];
    logic signed [DET_W-1:0]    lane_det [FIELD_COUNT];
    logic [QUOT_W-1:0]          lane_quot [FIELD_COUNT];
    logic [FIELD_COUNT-1:0]     lane_neg;
    det_mag_t                   det_mags;
    norm_mag_t                  norm_mags;
    logic [LEN_W-1:0]           norm_len;
    logic                       norm_zero, norm_done, norm_start;

    // clamp N into the supported range; k rows are loaded per normal
    always_comb
    begin
        if (dim_reg < DIM_W'(2))
            n_eff = DIM_W'(2);
        else if (dim_reg > DIM_W'(DIM_LIMIT))
            n_eff = DIM_W'(DIM_LIMIT);
        else
            n_eff = dim_reg;
    end
    assign k_eff = ROW_IDX_W'(n_eff - DIM_W'(1));

    // hold the input while computing or while a cfg write is offered
    assign in_stall  = (state_reg != ST_LOAD) || cfg_valid;
    assign cfg_ready = (state_reg == ST_LOAD);
    assign in_take   = in_valid && !in_stall;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign out_take  = out_valid_reg && !out_stall;
    assign row_write = in_take;

    // per-lane minor: drop column d, pad unused rows/columns with identity
    for (genvar d = 0; d < FIELD_COUNT; d++)
    begin : g_lane
        always_comb
        begin
            for (int r = 0; r < ROW_DEPTH; r++)
            begin
                for (int j = 0; j < ROW_DEPTH; j++)
                begin
                    if ((ROW_IDX_W'(r) < k_eff) && (ROW_IDX_W'(j) < k_eff))
                        lane_mat[d][r*ROW_DEPTH+j] = ENTRY_W'($signed(
                            row_store_reg[r][((j < d) ? j : j + 1)*COMP_W +: COMP_W]));
                    else if (r == j)
                        lane_mat[d][r*ROW_DEPTH+j] = ENTRY_W'(1);
                    else
                        lane_mat[d][r*ROW_DEPTH+j] = '0;
                end
            end
        end

        hun_lane u_lane
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (lane_ctl),
            .mat   (lane_mat[d]),
            .mag   (norm_mags[d]),
            .len   (norm_len),
            .det   (lane_det[d]),
            .quot  (lane_quot[d]),
            .stat  (lane_stat[d])
        );

        // apply the alternating sign, mask components at or above N
        always_comb
        begin
            logic signed [DET_W-1:0] v;
            v = (d % 2 == 1) ? -lane_det[d] : lane_det[d];
            if (DIM_W'(d) < n_eff)
            begin
                lane_neg[d] = v[DET_W-1];
                det_mags[d] = v[DET_W-1] ? DET_W'(-v) : DET_W'(v);
            end
            else
            begin
                lane_neg[d] = 1'b0;
                det_mags[d] = '0;
            end
        end
    end

    hun_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (norm_start),
        .mags      (det_mags),
        .norm_mags (norm_mags),
        .len       (norm_len),
        .zero      (norm_zero),
        .done      (norm_done)
    );

    // sequencer: load rows, then determinants, merge, divide unless all are zero, hand off
    always_comb
    begin
        state_next         = state_reg;
        dim_next           = dim_reg;
        rows_loaded_next   = rows_loaded_reg;
        neg_next           = neg_reg;
        out_valid_next     = out_valid_reg;
        status_next        = status_reg;
        lane_ctl           = '0;
        norm_start         = 1'b0;
        for (int i = 0; i < FIELD_COUNT; i++)
            normal_next[i] = normal_reg[i];
        if (out_take)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (cfg_take)
                begin
                    dim_next         = dimension_count;
                    rows_loaded_next = '0;
                end
                else if (in_take)
                begin
                    if (rows_loaded_reg + ROW_IDX_W'(1) == k_eff)
                    begin
                        rows_loaded_next   = '0;
                        lane_ctl.det_start = 1'b1;
                        state_next         = ST_DET;
                    end
                    else
                    begin
                        rows_loaded_next = rows_loaded_reg + ROW_IDX_W'(1);
                    end
                end
            end
            ST_DET:
            begin
                if (lane_stat[0].det_done)
                begin
                    neg_next   = lane_neg;
                    norm_start = 1'b1;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (norm_done)
                begin
                    if (norm_zero)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        lane_ctl.div_start = 1'b1;
                        state_next         = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (lane_stat[0].div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = norm_zero;
                    for (int i = 0; i < FIELD_COUNT; i++)
                    begin
                        if (norm_zero)
                            normal_next[i] = '0;
                        else if (neg_reg[i])
                            normal_next[i] = -COMP_W'(lane_quot[i]);
                        else
                            normal_next[i] = COMP_W'(lane_quot[i]);
                    end
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            dim_reg         <= DIM_W'(3);
            rows_loaded_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            dim_reg         <= dim_next;
            rows_loaded_reg <= rows_loaded_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_write)
            row_store_reg[rows_loaded_reg] <= {comp_3, comp_2, comp_1, comp_0};
        neg_reg    <= neg_next;
        status_reg <= status_next;
        for (int i = 0; i < FIELD_COUNT; i++)
            normal_reg[i] <= normal_next[i];
    end

    assign out_valid = out_valid_reg;
    assign normal_0  = normal_reg[0];
    assign normal_1  = normal_reg[1];
    assign normal_2  = normal_reg[2];
    assign normal_3  = normal_reg[3];
    assign status    = status_reg;

    // a collinear result carries an all-zero normal
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |->
            normal_0 == '0 && normal_1 == '0 && normal_2 == '0 && normal_3 == '0)
        else $error("collinear status with nonzero normal");

    // fill count never reaches the row store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        rows_loaded_reg < ROW_IDX_W'(ROW_DEPTH))
        else $error("row count out of range");

    // a nonzero normal has been scaled into range: length at least 2^29
    assert property (@(posedge clk) disable iff (!rst_n)
        norm_done && !norm_zero |-> norm_len[LEN_W-1:LEN_W-2] != 2'b00)
        else $error("length below normalized range");

    // lanes never start a divide outside the divide handoff
    assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctl.div_start |-> state_reg == ST_NORM && norm_done && !norm_zero)
        else $error("divide started out of sequence");

endmodule

### verif/hyperplane_unit_normal_core_tb.sv
// Testbench for hyperplane_unit_normal_core: loads sets of spanning vectors,
// predicts each unit normal in a scoreboard class, checks every output item.
// Depends on hun_pkg and the core RTL.
`timescale 1ns / 100ps

module hyperplane_unit_normal_core_tb;
    import hun_pkg::*;

    typedef struct {
        logic signed [15:0] nrm [4];
        logic               coll;
    } normal_t;

    // Predict the unit normal from the loaded rows and check output items.
    class normal_scoreboard;
        logic signed [15:0] rows [3][4];
        int unsigned        loaded;
        logic [2:0]         dims_reg;
        normal_t            pending [$];
        int unsigned        errors;

        function void reset_state();
            loaded = 0;
            dims_reg = 3;
            pending.delete();
            errors = 0;
        endfunction

        function void set_dims(logic [2:0] v);
            dims_reg = v;
            loaded = 0;
        endfunction

        function int unsigned eff_dims();
            int unsigned n;
            n = dims_reg;
            if (n < 2) n = 2;
            if (n > DIM_LIMIT) n = DIM_LIMIT;
            return n;
        endfunction

        function longint det_k(longint m [3][3], int unsigned k);
            if (k == 1) return m[0][0];
            if (k == 2) return m[0][0] * m[1][1] - m[0][1] * m[1][0];
            return m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
                 - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
                 + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
        endfunction

        function longint unsigned root64(longint unsigned x);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv >>= 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        function normal_t unit_normal();
            normal_t             r;
            int unsigned         n, k, col;
            longint              mat [3][3];
            longint              v;
            longint unsigned     mag [4];
            bit                  neg [4];
            longint unsigned     mx, sumsq, len, q;
            n = eff_dims();
            k = n - 1;
            mx = 0;
            sumsq = 0;
            r.coll = 0;
            for (int d = 0; d < 4; d++) begin
                r.nrm[d] = 0;
                mag[d] = 0;
                neg[d] = 0;
            end
            for (int d = 0; d < n; d++) begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) mat[i][j] = 0;
                for (int i = 0; i < k; i++) begin
                    col = 0;
                    for (int c = 0; c < n; c++)
                        if (c != d) begin
                            mat[i][col] = rows[i][c];
                            col++;
                        end
                end
                v = det_k(mat, k);
                if (d % 2) v = -v;
                neg[d] = v < 0;
                mag[d] = neg[d] ? -v : v;
                if (mag[d] > mx) mx = mag[d];
            end
            if (mx == 0) begin
                r.coll = 1;
                return r;
            end
            while (mx >= (64'd1 << 30)) begin
                for (int d = 0; d < n; d++) mag[d] >>= 1;
                mx >>= 1;
            end
            while (mx < (64'd1 << 29)) begin
                for (int d = 0; d < n; d++) mag[d] <<= 1;
                mx <<= 1;
            end
            for (int d = 0; d < n; d++) sumsq += mag[d] * mag[d];
            len = root64(sumsq);
            if (len == 0) len = 1;
            for (int d = 0; d < n; d++) begin
                q = (mag[d] * 16384 + len / 2) / len;
                if (neg[d]) q = -q;
                r.nrm[d] = q[15:0];
            end
            return r;
        endfunction

        // Note an accepted vector; queue a normal when the set is complete.
        function void note_vector(logic signed [15:0] c [4]);
            if (loaded >= 3) loaded = 0;
            rows[loaded] = c;
            loaded = (loaded + 1) % 4;
            if (loaded >= eff_dims() - 1) begin
                pending.insert(pending.size(), unit_normal());
                loaded = 0;
            end
        endfunction

        function void check_normal(normal_t got);
            normal_t exp_n;
            if (pending.size() == 0) begin
                $display("%0t: unexpected output item n=%0d,%0d,%0d,%0d s=%0d", $time,
                         got.nrm[0], got.nrm[1], got.nrm[2], got.nrm[3], got.coll);
                errors++;
                return;
            end
            exp_n = pending.pop_front();
            for (int d = 0; d < 4; d++)
                if (got.nrm[d] !== exp_n.nrm[d]) begin
                    $display("%0t: normal_%0d expected %0d actual %0d", $time, d,
                             exp_n.nrm[d], got.nrm[d]);
                    errors++;
                end
            if (got.coll !== exp_n.coll) begin
                $display("%0t: status expected %0d actual %0d", $time,
                         exp_n.coll, got.coll);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [DIM_W-1:0]         dimension_count;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [COMP_W-1:0] comp_0, comp_1, comp_2, comp_3;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [COMP_W-1:0] normal_0, normal_1, normal_2, normal_3;
    logic                     status;

    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_SETS = 752;

    normal_scoreboard sb;
    bit               calm;      // no idling in the last part of the run
    int unsigned      quiet;     // cycles with no accepted item

    hyperplane_unit_normal_core uut (.*);

    initial clk = 0;
    always #1 clk = ~clk;

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("hyperplane_unit_normal_core verification failed");
            $finish;
        end
    end

    // Sample output items at the rising edge.
    always @(posedge clk) begin
        normal_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.nrm[0] = normal_0;
            got.nrm[1] = normal_1;
            got.nrm[2] = normal_2;
            got.nrm[3] = normal_3;
            got.coll = status;
            sb.check_normal(got);
        end
    end

    // Receiver: stall in random bursts, with long open stretches.
    initial begin
        out_stall = 0;
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 19) == 0) begin
                out_stall <= 1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic write_dims(input logic [2:0] v);
        @(negedge clk);
        cfg_valid <= 1;
        dimension_count <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_dims(v);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // Send one vector; optionally idle first. Valid is driven with blocking
    // assignments so back-to-back items keep it high across the falling edge.
    task automatic send_vector(input logic signed [15:0] c [4]);
        if (!calm && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 14)) @(negedge clk);
        in_valid = 1;
        comp_0 = c[0];
        comp_1 = c[1];
        comp_2 = c[2];
        comp_3 = c[3];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_vector(c);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic send_fields(input int a, input int b, input int c, input int d);
        logic signed [15:0] v [4];
        v[0] = 16'(a);
        v[1] = 16'(b);
        v[2] = 16'(c);
        v[3] = 16'(d);
        send_vector(v);
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(0, 15)) - 8);
            default: return 16'($urandom());
        endcase
    endfunction

    // Drain outstanding normals, then let the core settle before a write.
    task automatic drain();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    initial begin
        logic signed [15:0] v [4];
        logic signed [15:0] base [4];
        logic [2:0]         dims_plan [8];
        sb = new();
        sb.reset_state();
        rst_n = 0;
        cfg_valid = 0;
        dimension_count = 3;
        in_valid = 0;
        comp_0 = 0;
        comp_1 = 0;
        comp_2 = 0;
        comp_3 = 0;
        calm = 0;
        quiet = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: reset dimension 3, axes, extremes, collinear rows.
        send_fields(4096, 0, 0, 0);
        send_fields(0, 4096, 0, 0);
        send_fields(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_fields(-32768, -32768, -32768, -32768);
        send_fields(-32768, 32767, -32768, 1);
        send_fields(32767, -32768, 5, -1);
        send_fields(0, 0, 0, 0);
        send_fields(1, 2, 3, 4);
        // Partly loaded set dropped by the write.
        send_fields(123, 456, 789, 1000);
        drain();
        write_dims(2);
        send_fields(0, 0, 0, 0);
        send_fields(-32768, 32767, 0, 0);
        send_fields(1, 0, -5, 9);
        drain();
        write_dims(4);
        send_fields(4096, 0, 0, 0);
        send_fields(0, 4096, 0, 0);
        send_fields(0, 0, 4096, 0);
        send_fields(32767, -32768, 32767, -32768);
        send_fields(-32768, 32767, -32768, 32767);
        send_fields(7, 7, 7, 7);
        drain();
        // Out-of-range settings clamp.
        write_dims(0);
        send_fields(3, 4, 0, 0);
        drain();
        write_dims(7);
        send_fields(1, 2, 3, 4);
        send_fields(-4, 3, 2, 1);
        send_fields(9, -9, 9, -9);
        drain();

        // Random sets across settings 1 to 6; the last pass runs without idling.
        dims_plan = '{3'd2, 3'd3, 3'd4, 3'd1, 3'd5, 3'd6, 3'd4, 3'd3};
        foreach (dims_plan[p]) begin
            write_dims(dims_plan[p]);
            if (p == 7) calm = 1;
            repeat (RANDOM_SETS / 8) begin
                int unsigned need;
                need = sb.eff_dims() - 1;
                // Occasionally build a set of dependent rows.
                for (int r = 0; r < need; r++) begin
                    for (int d = 0; d < 4; d++) v[d] = rand_comp();
                    if (r == 0) base = v;
                    else if ($urandom_range(0, 9) == 0) begin
                        for (int d = 0; d < 4; d++)
                            v[d] = ($urandom_range(0, 1)) ? -base[d] : base[d];
                    end
                    send_vector(v);
                end
            end
            // Leave a partial set now and then to be dropped by the next write.
            if ($urandom_range(0, 1) && sb.eff_dims() > 2 && p != 7) begin
                for (int d = 0; d < 4; d++) v[d] = rand_comp();
                send_vector(v);
            end
            drain();
        end

        if (sb.errors == 0)
            $display("hyperplane_unit_normal_core verification clean");
        else
            $display("hyperplane_unit_normal_core verification failed");
        $finish;
    end
endmodule

### sim.f
rtl/core/hun_pkg.sv
rtl/core/hun_lane.sv
rtl/core/hun_norm.sv
rtl/core/hyperplane_unit_normal_core.sv
verif/hyperplane_unit_normal_core_tb.sv
